@@ sv/spfm_pkg.sv @@
`timescale 1ns / 1ps
// Shared types, constants and helper functions for the salt/pepper
// directional mean filter. No dependencies.
package spfm_pkg;

    localparam int MAX_WIDTH  = 512;
    localparam int MAX_HEIGHT = 512;
    localparam int MAX_DIM    = (MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT;

    localparam int FIELD_W   = 9;                    // row / col field width
    localparam int POS_W     = FIELD_W;
    localparam int COL_W     = $clog2(MAX_WIDTH);
    localparam int ROW_W     = $clog2(MAX_HEIGHT);
    localparam int ADDR_W    = ROW_W + COL_W;
    localparam int DIM_W     = $clog2(MAX_DIM + 1);
    localparam int PIX_W     = 8;
    localparam int CFG_W     = 10;
    localparam int CFG_IDX_W = 2;
    localparam int CNT_W     = 3;
    localparam int SUM_W     = 10;                   // 4 * 255 fits

    localparam logic [CFG_W-1:0] DIM_RESET        = CFG_W'(512);
    localparam logic [PIX_W-1:0] NOISE_LOW_RESET  = PIX_W'(0);
    localparam logic [PIX_W-1:0] NOISE_HIGH_RESET = PIX_W'(255);

    // x / 3 == (x * 683) >> 11 for every x up to 4 * 255
    localparam int RECIP3_W  = 10;
    localparam logic [RECIP3_W-1:0] RECIP3 = RECIP3_W'(683);
    localparam int RECIP3_SH = 11;
    localparam int PROD_W    = SUM_W + RECIP3_W;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_FRAME_WIDTH,
        REG_FRAME_HEIGHT,
        REG_NOISE_LOW,
        REG_NOISE_HIGH
    } cfg_reg_t;

    typedef enum logic {
        OP_WRITE,
        OP_READ
    } op_t;

    typedef enum logic [1:0] {
        W_IDLE,
        W_CENTER,
        W_SEARCH,
        W_DONE
    } walk_state_t;

    typedef enum logic [1:0] {
        DIR_UP,
        DIR_DOWN,
        DIR_RIGHT,
        DIR_LEFT
    } dir_t;

    typedef struct packed {
        logic               op;
        logic [FIELD_W-1:0] row;
        logic [FIELD_W-1:0] col;
        logic [PIX_W-1:0]   pixel;
    } req_word_t;

    typedef struct packed {
        logic [PIX_W-1:0] filtered_pixel;
        logic             was_noise;
        logic [CNT_W-1:0] clean_found;
    } rsp_word_t;

    typedef struct packed {
        logic [DIM_W-1:0] eff_w;
        logic [DIM_W-1:0] eff_h;
        logic [PIX_W-1:0] noise_low;
        logic [PIX_W-1:0] noise_high;
    } cfg_t;

    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
        logic [PIX_W-1:0]  data;
    } ram_wr_t;

    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
    } ram_rd_t;

    typedef struct packed {
        logic [SUM_W-1:0] sum;
        logic [CNT_W-1:0] cnt;
        logic             was_noise;
    } mean_req_t;

    function automatic logic [DIM_W-1:0] eff_dim(input logic [CFG_W-1:0] v,
                                                 input int maxv);
        if (v == '0)
            return DIM_W'(1);
        if (int'(v) > maxv)
            return DIM_W'(maxv);
        return DIM_W'(v);
    endfunction

    function automatic logic is_noise(input logic [PIX_W-1:0] v, input cfg_t c);
        return (v == c.noise_low) || (v == c.noise_high);
    endfunction

endpackage

@@ sv/spfm_frame_ram.sv @@
`timescale 1ns / 1ps
// Frame store: one write port, one read port, registered read data.
// Depends on spfm_pkg.
module spfm_frame_ram (
    input  logic                          clk,
    input  spfm_pkg::ram_wr_t             wr,
    input  spfm_pkg::ram_rd_t             rd,
    output logic [spfm_pkg::PIX_W-1:0]    data
);

    localparam int DEPTH = spfm_pkg::MAX_WIDTH * spfm_pkg::MAX_HEIGHT;

    logic [spfm_pkg::PIX_W-1:0] mem [DEPTH];
    logic [spfm_pkg::PIX_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr] <= wr.data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd.en)
        begin
            rd_data_reg <= mem[rd.addr];
        end
    end

    assign data = rd_data_reg;

endmodule

@@ sv/spfm_walker.sv @@
`timescale 1ns / 1ps
// Request sequencer: stores pixels, reads the center pixel and walks the
// four directions through the frame store, accumulating clean neighbors.
// Depends on spfm_pkg.
module spfm_walker (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          req_valid,
    output logic                          req_ready,
    input  spfm_pkg::req_word_t           req,
    input  spfm_pkg::cfg_t                cfg,
    output spfm_pkg::ram_wr_t             ram_wr,
    output spfm_pkg::ram_rd_t             ram_rd,
    input  logic [spfm_pkg::PIX_W-1:0]    ram_data,
    output logic                          mreq_valid,
    input  logic                          mreq_ready,
    output spfm_pkg::mean_req_t           mreq
);

    spfm_pkg::walk_state_t state_reg, state_next;
    spfm_pkg::dir_t        dir_reg, dir_next, dir_load;
    logic [spfm_pkg::POS_W-1:0] row_reg, row_next;
    logic [spfm_pkg::POS_W-1:0] col_reg, col_next;
    logic [spfm_pkg::POS_W-1:0] pos_reg, pos_next, load_pos;
    logic [spfm_pkg::DIM_W-1:0] rem_reg, rem_next, load_rem;
    logic                       pend_reg, pend_next;
    logic [spfm_pkg::SUM_W-1:0] sum_reg, sum_next;
    logic [spfm_pkg::CNT_W-1:0] cnt_reg, cnt_next;
    logic                       noise_reg, noise_next;
    logic                       accept;
    logic                       in_frame;
    logic                       advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= spfm_pkg::W_IDLE;
            pend_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            pend_reg  <= pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dir_reg   <= dir_next;
        row_reg   <= row_next;
        col_reg   <= col_next;
        pos_reg   <= pos_next;
        rem_reg   <= rem_next;
        sum_reg   <= sum_next;
        cnt_reg   <= cnt_next;
        noise_reg <= noise_next;
    end

    // start point and step budget of the direction about to be walked
    always_comb
    begin
        dir_load = (state_reg == spfm_pkg::W_CENTER) ? spfm_pkg::DIR_UP
                                                     : spfm_pkg::dir_t'(dir_reg + 2'd1);
        unique case (dir_load)
            spfm_pkg::DIR_UP:
            begin
                load_pos = row_reg - spfm_pkg::POS_W'(1);
                load_rem = spfm_pkg::DIM_W'(row_reg);
            end
            spfm_pkg::DIR_DOWN:
            begin
                load_pos = row_reg + spfm_pkg::POS_W'(1);
                load_rem = cfg.eff_h - spfm_pkg::DIM_W'(1) - spfm_pkg::DIM_W'(row_reg);
            end
            spfm_pkg::DIR_RIGHT:
            begin
                load_pos = col_reg + spfm_pkg::POS_W'(1);
                load_rem = cfg.eff_w - spfm_pkg::DIM_W'(1) - spfm_pkg::DIM_W'(col_reg);
            end
            default:
            begin
                load_pos = col_reg - spfm_pkg::POS_W'(1);
                load_rem = spfm_pkg::DIM_W'(col_reg);
            end
        endcase
    end

    assign req_ready = (state_reg == spfm_pkg::W_IDLE);
    assign accept    = req_valid && req_ready;
    assign in_frame  = (spfm_pkg::DIM_W'(req.row) < cfg.eff_h) &&
                       (spfm_pkg::DIM_W'(req.col) < cfg.eff_w);

    always_comb
    begin
        state_next = state_reg;
        dir_next   = dir_reg;
        row_next   = row_reg;
        col_next   = col_reg;
        pos_next   = pos_reg;
        rem_next   = rem_reg;
        pend_next  = pend_reg;
        sum_next   = sum_reg;
        cnt_next   = cnt_reg;
        noise_next = noise_reg;
        advance    = 1'b0;
        mreq_valid = (state_reg == spfm_pkg::W_DONE);
        ram_wr     = '0;
        ram_rd     = '0;

        unique case (state_reg)
            spfm_pkg::W_IDLE:
            begin
                if (accept)
                begin
                    if (req.op == spfm_pkg::OP_WRITE)
                    begin
                        ram_wr.en   = in_frame;
                        ram_wr.addr = {spfm_pkg::ROW_W'(req.row), spfm_pkg::COL_W'(req.col)};
                        ram_wr.data = req.pixel;
                    end
                    else if (in_frame)
                    begin
                        row_next    = req.row;
                        col_next    = req.col;
                        ram_rd.en   = 1'b1;
                        ram_rd.addr = {spfm_pkg::ROW_W'(req.row), spfm_pkg::COL_W'(req.col)};
                        state_next  = spfm_pkg::W_CENTER;
                    end
                    else
                    begin
                        sum_next   = '0;
                        cnt_next   = '0;
                        noise_next = 1'b0;
                        state_next = spfm_pkg::W_DONE;
                    end
                end
            end

            spfm_pkg::W_CENTER:
            begin
                sum_next = '0;
                cnt_next = '0;
                if (!spfm_pkg::is_noise(ram_data, cfg))
                begin
                    sum_next   = spfm_pkg::SUM_W'(ram_data);
                    noise_next = 1'b0;
                    state_next = spfm_pkg::W_DONE;
                end
                else
                begin
                    noise_next = 1'b1;
                    dir_next   = spfm_pkg::DIR_UP;
                    pos_next   = load_pos;
                    rem_next   = load_rem;
                    pend_next  = 1'b0;
                    state_next = spfm_pkg::W_SEARCH;
                end
            end

            spfm_pkg::W_SEARCH:
            begin
                // one read issued per cycle while the walk passes noise; the word read last cycle is checked now
                if (pend_reg && !spfm_pkg::is_noise(ram_data, cfg))
                begin
                    sum_next = sum_reg + spfm_pkg::SUM_W'(ram_data);
                    cnt_next = cnt_reg + spfm_pkg::CNT_W'(1);
                    advance  = 1'b1;
                end
                else if (rem_reg != '0)
                begin
                    ram_rd.en = 1'b1;
                    if (dir_reg == spfm_pkg::DIR_UP || dir_reg == spfm_pkg::DIR_DOWN)
                    begin
                        ram_rd.addr = {spfm_pkg::ROW_W'(pos_reg), spfm_pkg::COL_W'(col_reg)};
                    end
                    else
                    begin
                        ram_rd.addr = {spfm_pkg::ROW_W'(row_reg), spfm_pkg::COL_W'(pos_reg)};
                    end
                    if (dir_reg == spfm_pkg::DIR_UP || dir_reg == spfm_pkg::DIR_LEFT)
                    begin
                        pos_next = pos_reg - spfm_pkg::POS_W'(1);
                    end
                    else
                    begin
                        pos_next = pos_reg + spfm_pkg::POS_W'(1);
                    end
                    rem_next  = rem_reg - spfm_pkg::DIM_W'(1);
                    pend_next = 1'b1;
                end
                else
                begin
                    advance = 1'b1;
                end

                if (advance)
                begin
                    pend_next = 1'b0;
                    if (dir_reg == spfm_pkg::DIR_LEFT)
                    begin
                        state_next = spfm_pkg::W_DONE;
                    end
                    else
                    begin
                        dir_next = dir_load;
                        pos_next = load_pos;
                        rem_next = load_rem;
                    end
                end
            end

            spfm_pkg::W_DONE:
            begin
                if (mreq_ready)
                begin
                    state_next = spfm_pkg::W_IDLE;
                end
            end

            default:
            begin
                state_next = spfm_pkg::W_IDLE;
            end
        endcase
    end

    assign mreq.sum       = sum_reg;
    assign mreq.cnt       = cnt_reg;
    assign mreq.was_noise = noise_reg;

endmodule

@@ sv/spfm_mean.sv @@
`timescale 1ns / 1ps
// Mean of the clean neighbors (sum over a count of 0..4) and the output
// register of the result channel. Depends on spfm_pkg.
module spfm_mean (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  mreq_valid,
    output logic                  mreq_ready,
    input  spfm_pkg::mean_req_t   mreq,
    output logic                  rsp_valid,
    input  logic                  rsp_ready,
    output spfm_pkg::rsp_word_t   rsp
);

    logic                          valid_reg;
    spfm_pkg::rsp_word_t           word_reg, word_next;
    logic [spfm_pkg::PROD_W-1:0]   prod;
    logic [spfm_pkg::SUM_W-1:0]    quot;
    logic                          load;

    assign mreq_ready = !valid_reg || rsp_ready;
    assign load       = mreq_valid && mreq_ready;

    assign prod = spfm_pkg::PROD_W'(mreq.sum) * spfm_pkg::PROD_W'(spfm_pkg::RECIP3);

    always_comb
    begin
        unique case (mreq.cnt)
            spfm_pkg::CNT_W'(1): quot = mreq.sum;
            spfm_pkg::CNT_W'(2): quot = mreq.sum >> 1;
            spfm_pkg::CNT_W'(3): quot = spfm_pkg::SUM_W'(prod >> spfm_pkg::RECIP3_SH);
            spfm_pkg::CNT_W'(4): quot = mreq.sum >> 2;
            default:             quot = '0;   // no clean direction
        endcase

        word_next.was_noise   = mreq.was_noise;
        word_next.clean_found = mreq.cnt;
        word_next.filtered_pixel = mreq.was_noise ? spfm_pkg::PIX_W'(quot)
                                                  : spfm_pkg::PIX_W'(mreq.sum);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (load)
        begin
            valid_reg <= 1'b1;
        end
        else if (rsp_ready)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            word_reg <= word_next;
        end
    end

    assign rsp_valid = valid_reg;
    assign rsp       = word_reg;

endmodule

@@ sv/salt_pepper_directional_mean_filter_unit.sv @@
`timescale 1ns / 1ps
// Top level of the salt/pepper directional mean filter: configuration
// registers, frame store, walker and mean/output stage. Depends on spfm_pkg.

// A write word stores one pixel and gives no result; a write outside the
// configured frame is dropped. A read word gives one result. A read of a
// noise pixel walks the four directions in turn through the single read
// port of the frame store, one pixel per cycle while it passes noise
// pixels, until it finds a clean neighbor or reaches the frame edge.
// The frame store is not cleared after reset: every pixel must be written
// before a read uses it. The next word is taken while a finished result
// waits in the output register.
module salt_pepper_directional_mean_filter_unit (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                req_valid,
    output logic                                req_ready,
    input  spfm_pkg::req_word_t                 req,
    output logic                                rsp_valid,
    input  logic                                rsp_ready,
    output spfm_pkg::rsp_word_t                 rsp,
    input  logic                                cfg_we,
    input  logic [spfm_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [spfm_pkg::CFG_W-1:0]          cfg_data
);

    logic [spfm_pkg::CFG_W-1:0] width_reg;
    logic [spfm_pkg::CFG_W-1:0] height_reg;
    logic [spfm_pkg::PIX_W-1:0] noise_low_reg;
    logic [spfm_pkg::PIX_W-1:0] noise_high_reg;

    spfm_pkg::cfg_t             cfg;
    spfm_pkg::ram_wr_t          ram_wr;
    spfm_pkg::ram_rd_t          ram_rd;
    logic [spfm_pkg::PIX_W-1:0] ram_data;
    logic                       mreq_valid;
    logic                       mreq_ready;
    spfm_pkg::mean_req_t        mreq;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg      <= spfm_pkg::DIM_RESET;
            height_reg     <= spfm_pkg::DIM_RESET;
            noise_low_reg  <= spfm_pkg::NOISE_LOW_RESET;
            noise_high_reg <= spfm_pkg::NOISE_HIGH_RESET;
        end
        else if (cfg_we)
        begin
            unique case (spfm_pkg::cfg_reg_t'(cfg_index))
                spfm_pkg::REG_FRAME_WIDTH:  width_reg      <= cfg_data;
                spfm_pkg::REG_FRAME_HEIGHT: height_reg     <= cfg_data;
                spfm_pkg::REG_NOISE_LOW:    noise_low_reg  <= cfg_data[spfm_pkg::PIX_W-1:0];
                spfm_pkg::REG_NOISE_HIGH:   noise_high_reg <= cfg_data[spfm_pkg::PIX_W-1:0];
                default:                    ;
            endcase
        end
    end

    assign cfg.eff_w      = spfm_pkg::eff_dim(width_reg, spfm_pkg::MAX_WIDTH);
    assign cfg.eff_h      = spfm_pkg::eff_dim(height_reg, spfm_pkg::MAX_HEIGHT);
    assign cfg.noise_low  = noise_low_reg;
    assign cfg.noise_high = noise_high_reg;

    spfm_frame_ram u_ram (
        .clk  (clk),
        .wr   (ram_wr),
        .rd   (ram_rd),
        .data (ram_data)
    );

    spfm_walker u_walker (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_valid  (req_valid),
        .req_ready  (req_ready),
        .req        (req),
        .cfg        (cfg),
        .ram_wr     (ram_wr),
        .ram_rd     (ram_rd),
        .ram_data   (ram_data),
        .mreq_valid (mreq_valid),
        .mreq_ready (mreq_ready),
        .mreq       (mreq)
    );

    spfm_mean u_mean (
        .clk        (clk),
        .rst_n      (rst_n),
        .mreq_valid (mreq_valid),
        .mreq_ready (mreq_ready),
        .mreq       (mreq),
        .rsp_valid  (rsp_valid),
        .rsp_ready  (rsp_ready),
        .rsp        (rsp)
    );

`ifndef ASSERT_OFF
    // a read word always leaves the walker busy in the cycle after it is taken
    a_read_busy: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready && (req.op == spfm_pkg::OP_READ) |=> !req_ready)
        else $error("walker took a new word right after a read");

    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> rsp.clean_found <= spfm_pkg::CNT_W'(4))
        else $error("clean_found above four");

    a_clean_no_search: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp.was_noise |-> rsp.clean_found == '0)
        else $error("search count on a clean pixel");

    a_no_neighbor_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.was_noise && (rsp.clean_found == '0)
            |-> rsp.filtered_pixel == '0)
        else $error("nonzero value without a clean neighbor");
`endif

endmodule

@@ dv/tb_salt_pepper_directional_mean_filter_unit.sv @@
`timescale 1ns / 1ps
// Self-checking bench for salt_pepper_directional_mean_filter_unit: loads frames of several
// sizes, reads filtered pixels and compares each result with an in-bench filter model.
// Depends on spfm_pkg and the RTL top level.
module tb_salt_pepper_directional_mean_filter_unit;
    import spfm_pkg::*;

    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int DRAIN_WAIT  = 20;

    // Holds a private copy of the frame and the registers; predicts one result per read word.
    class pixel_scoreboard;
        logic [PIX_W-1:0] frame_copy [MAX_WIDTH*MAX_HEIGHT];
        logic [CFG_W-1:0] width_reg;
        logic [CFG_W-1:0] height_reg;
        logic [PIX_W-1:0] pepper;
        logic [PIX_W-1:0] salt;
        rsp_word_t        pending_pixels [$];
        int               mismatches;

        function new();
            width_reg  = DIM_RESET;
            height_reg = DIM_RESET;
            pepper     = NOISE_LOW_RESET;
            salt       = NOISE_HIGH_RESET;
            mismatches = 0;
        endfunction

        function void set_reg(cfg_reg_t idx, logic [CFG_W-1:0] d);
            case (idx)
                REG_FRAME_WIDTH:  width_reg  = d;
                REG_FRAME_HEIGHT: height_reg = d;
                REG_NOISE_LOW:    pepper     = d[PIX_W-1:0];
                REG_NOISE_HIGH:   salt       = d[PIX_W-1:0];
                default: ;
            endcase
        endfunction

        // zero counts as one, oversize counts as the maximum
        function int clamp_dim(logic [CFG_W-1:0] v, int maxv);
            if (v == '0)
                return 1;
            if (int'(v) > maxv)
                return maxv;
            return int'(v);
        endfunction

        function int eff_cols();
            return clamp_dim(width_reg, MAX_WIDTH);
        endfunction

        function int eff_rows();
            return clamp_dim(height_reg, MAX_HEIGHT);
        endfunction

        function logic noisy(logic [PIX_W-1:0] v);
            return (v == pepper) || (v == salt);
        endfunction

        function logic [PIX_W-1:0] pixel_at(int r, int c);
            return frame_copy[r*MAX_WIDTH + c];
        endfunction

        function rsp_word_t filter_pixel(int r, int c);
            rsp_word_t        res;
            int               rows;
            int               cols;
            int               total;
            int               dirs;
            int               k;
            logic [PIX_W-1:0] v;
            res  = '0;
            rows = eff_rows();
            cols = eff_cols();
            if (r >= rows || c >= cols)
                return res;
            v = pixel_at(r, c);
            if (!noisy(v))
            begin
                res.filtered_pixel = v;
                return res;
            end
            total = 0;
            dirs  = 0;
            for (k = r - 1; k >= 0; k--)
                if (!noisy(pixel_at(k, c)))
                begin
                    total += pixel_at(k, c);
                    dirs++;
                    break;
                end
            for (k = r + 1; k < rows; k++)
                if (!noisy(pixel_at(k, c)))
                begin
                    total += pixel_at(k, c);
                    dirs++;
                    break;
                end
            for (k = c + 1; k < cols; k++)
                if (!noisy(pixel_at(r, k)))
                begin
                    total += pixel_at(r, k);
                    dirs++;
                    break;
                end
            for (k = c - 1; k >= 0; k--)
                if (!noisy(pixel_at(r, k)))
                begin
                    total += pixel_at(r, k);
                    dirs++;
                    break;
                end
            res.was_noise      = 1'b1;
            res.clean_found    = CNT_W'(dirs);
            res.filtered_pixel = (dirs > 0) ? PIX_W'(total / dirs) : '0;
            return res;
        endfunction

        function void note_word(req_word_t w);
            int r;
            int c;
            r = int'(w.row);
            c = int'(w.col);
            if (w.op == OP_READ)
                pending_pixels.push_back(filter_pixel(r, c));
            else if (r < eff_rows() && c < eff_cols())
                frame_copy[r*MAX_WIDTH + c] = w.pixel;
        endfunction

        function void report(string msg);
            mismatches++;
            if (mismatches <= 10)
                $display("%0t: %s", $time, msg);
        endfunction

        function void check_word(rsp_word_t got);
            rsp_word_t want;
            if (pending_pixels.size() == 0)
            begin
                report($sformatf("result with no read pending: pixel %0d noise %0b found %0d",
                                 got.filtered_pixel, got.was_noise, got.clean_found));
                return;
            end
            want = pending_pixels.pop_front();
            if (got.filtered_pixel !== want.filtered_pixel || got.was_noise !== want.was_noise
                || got.clean_found !== want.clean_found)
                report($sformatf({"mismatch: expected pixel %0d noise %0b found %0d, ",
                                  "got pixel %0d noise %0b found %0d"},
                                 want.filtered_pixel, want.was_noise, want.clean_found,
                                 got.filtered_pixel, got.was_noise, got.clean_found));
        endfunction

        function int pending();
            return pending_pixels.size();
        endfunction
    endclass

    logic                 clk;
    logic                 rst_n;
    logic                 req_valid;
    logic                 req_ready;
    req_word_t            req;
    logic                 rsp_valid;
    logic                 rsp_ready;
    rsp_word_t            rsp;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_data;

    pixel_scoreboard board = new();
    bit              frame_written [MAX_WIDTH*MAX_HEIGHT];
    int              burst_left = 0;
    int              ready_run  = 0;
    int              ready_gap  = 0;
    int              cycle_count = 0;

    salt_pepper_directional_mean_filter_unit DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    always @(posedge clk)
    begin
        if (rst_n && req_valid && req_ready)
            board.note_word(req);
        if (rst_n && rsp_valid && rsp_ready)
            board.check_word(rsp);
    end

    // receiver: ready runs of random length, short stalls, now and then a long clean stretch
    always @(negedge clk)
    begin
        if (ready_run > 0)
        begin
            ready_run--;
            rsp_ready <= 1'b1;
        end
        else if (ready_gap > 0)
        begin
            ready_gap--;
            rsp_ready <= 1'b0;
        end
        else
        begin
            rsp_ready <= 1'b1;
            ready_run = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                                     : $urandom_range(0, 12);
            ready_gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
        end
    end

    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("salt_pepper_directional_mean_filter_unit test failed");
        $finish;
    end

    // sender: bursts of words with random gaps between them
    task automatic send_item(req_word_t w);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
            if (gap > 0)
            begin
                req_valid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(40, 120)
                                                      : $urandom_range(1, 16);
        end
        burst_left--;
        req       <= w;
        req_valid <= 1'b1;
        do @(posedge clk); while (!req_ready);
        @(negedge clk);
    endtask

    task automatic send_pixel(op_t op, int r, int c, int p);
        req_word_t w;
        w.op    = op;
        w.row   = FIELD_W'(r);
        w.col   = FIELD_W'(c);
        w.pixel = PIX_W'(p);
        if (op == OP_WRITE && r < board.eff_rows() && c < board.eff_cols())
            frame_written[r*MAX_WIDTH + c] = 1'b1;
        send_item(w);
    endtask

    task automatic wait_for_results();
        req_valid <= 1'b0;
        burst_left = 0;
        do @(negedge clk); while (board.pending() != 0);
    endtask

    task automatic write_reg(cfg_reg_t idx, logic [CFG_W-1:0] d);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= d;
        board.set_reg(idx, d);
        @(negedge clk);
    endtask

    task automatic set_frame(int w, int h, int lo, int hi);
        wait_for_results();
        // a trailing pixel write may still be in flight
        repeat (16) @(negedge clk);
        write_reg(REG_FRAME_WIDTH, CFG_W'(w));
        write_reg(REG_FRAME_HEIGHT, CFG_W'(h));
        write_reg(REG_NOISE_LOW, CFG_W'(lo));
        write_reg(REG_NOISE_HIGH, CFG_W'(hi));
        cfg_we <= 1'b0;
    endtask

    function automatic int rand_pixel(int pct);
        if ($urandom_range(0, 99) < pct)
            return $urandom_range(0, 1) ? int'(board.pepper) : int'(board.salt);
        return $urandom_range(0, 255);
    endfunction

    task automatic pick_outside(output int r, output int c);
        int rows;
        int cols;
        rows = board.eff_rows();
        cols = board.eff_cols();
        r    = $urandom_range(0, MAX_HEIGHT - 1);
        c    = $urandom_range(0, MAX_WIDTH - 1);
        if (rows < MAX_HEIGHT && (cols == MAX_WIDTH || $urandom_range(0, 1)))
            r = $urandom_range(rows, MAX_HEIGHT - 1);
        else
            c = $urandom_range(cols, MAX_WIDTH - 1);
    endtask

    // every pixel a walk can touch must be written before any read
    task automatic fill_frame(int pct);
        int r;
        int c;
        for (r = 0; r < board.eff_rows(); r++)
            for (c = 0; c < board.eff_cols(); c++)
                if (!frame_written[r*MAX_WIDTH + c])
                    send_pixel(OP_WRITE, r, c, rand_pixel(pct));
    endtask

    task automatic run_phase(int w, int h, int lo, int hi, int items, int pct);
        int  done;
        int  k;
        int  r;
        int  c;
        bit  held;
        set_frame(w, h, lo, hi);
        fill_frame(pct);
        done = 0;
        held = 1'b0;
        while (done < items)
        begin
            if (!held && done >= items / 2)
            begin
                wait_for_results();
                held = 1'b1;
            end
            k = $urandom_range(0, 99);
            if (k < 5)
            begin
                // dropped by the block, so not counted
                pick_outside(r, c);
                send_pixel(OP_WRITE, r, c, rand_pixel(pct));
            end
            else
            begin
                if (k < 50)
                begin
                    pick_outside(r, c);
                    if (k < 45)
                    begin
                        r = $urandom_range(0, board.eff_rows() - 1);
                        c = $urandom_range(0, board.eff_cols() - 1);
                        send_pixel(OP_WRITE, r, c, rand_pixel(pct));
                    end
                    else
                        send_pixel(OP_READ, r, c, $urandom_range(0, 255));
                end
                else
                begin
                    r = $urandom_range(0, board.eff_rows() - 1);
                    c = $urandom_range(0, board.eff_cols() - 1);
                    send_pixel(OP_READ, r, c, $urandom_range(0, 255));
                end
                done++;
            end
        end
    endtask

    initial
    begin
        int r;
        int c;
        req_valid = 1'b0;
        req       = '0;
        rsp_ready = 1'b0;
        cfg_we    = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        rst_n     = 1'b0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // directed: 3x3 frame, all noise, then clean neighbors added one side at a time
        set_frame(3, 3, 0, 255);
        for (r = 0; r < 3; r++)
            for (c = 0; c < 3; c++)
                send_pixel(OP_WRITE, r, c, ((r*3 + c) % 2) ? 255 : 0);
        send_pixel(OP_READ, 1, 1, 0);       // no clean direction
        send_pixel(OP_WRITE, 0, 1, 250);
        send_pixel(OP_WRITE, 2, 1, 251);
        send_pixel(OP_WRITE, 1, 0, 253);
        send_pixel(OP_WRITE, 1, 2, 254);
        send_pixel(OP_READ, 1, 1, 0);       // all four directions
        send_pixel(OP_READ, 0, 0, 0);       // corner, two directions
        send_pixel(OP_READ, 0, 1, 255);     // clean pixel passes through
        send_pixel(OP_WRITE, 1, 2, 255);
        send_pixel(OP_READ, 1, 1, 0);       // three directions
        send_pixel(OP_READ, 0, 2, 0);       // one direction
        send_pixel(OP_READ, 3, 0, 0);       // outside the frame
        send_pixel(OP_READ, 511, 511, 255);
        send_pixel(OP_WRITE, 0, 511, 90);   // outside, dropped
        send_pixel(OP_WRITE, 511, 0, 255);
        send_pixel(OP_READ, 2, 2, 255);

        run_phase(8, 8, 0, 255, 40, 45);
        run_phase(1023, 0, 'h311, 'h0C8, 30, 90);
        run_phase(0, 40, 255, 0, 30, 85);
        run_phase(16, 3, 5, 5, 30, 50);
        run_phase(3, 16, 100, 101, 30, 50);
        run_phase(2, 2, 0, 255, 20, 60);
        run_phase(1, 1, 9, 9, 15, 50);
        run_phase(12, 10, 0, 255, 40, 55);
        run_phase(512, 1, 0, 255, 15, 70);

        wait_for_results();
        repeat (DRAIN_WAIT) @(negedge clk);
        if (board.mismatches == 0 && board.pending() == 0)
            $display("salt_pepper_directional_mean_filter_unit test passed");
        else
            $display("salt_pepper_directional_mean_filter_unit test failed");
        $finish;
    end
endmodule
